// ----- rtl/bounded_deque_with_search_unit_defines.svh -----
// assertion macros for the bounded deque with search unit
// used by the checker; expects clk and rst_n in scope
`ifndef BOUNDED_DEQUE_WITH_SEARCH_UNIT_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication, off while in reset
`define BDQ_CHK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define BDQ_CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, also live during reset
`define BDQ_CHK_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bdq_pkg.sv -----
// shared types and codes for the bounded deque with search unit
// no dependencies
package bdq_pkg;

  localparam int REQ_W     = 3;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 5;

  // command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_SEARCH     = 3'd4,
    REQ_REVERSE    = 3'd5
  } req_code_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUSH,
    OP_POP,
    OP_SEARCH,
    OP_REVERSE
  } op_kind_t;

  // classified request
  typedef struct packed {
    op_kind_t               kind;
    logic                   log_front;
    logic [VAL_W-1:0]       value;
  } bdq_op_t;

  // result item
  typedef struct packed {
    status_t                status;
    logic                   found;
    logic signed [VAL_W-1:0] removed_value;
    logic [CNT_OUT_W-1:0]   entry_count;
  } bdq_rsp_t;

endpackage

// ----- rtl/bdq_if.sv -----
// request and result channel interfaces for the deque unit
// depends on bdq_pkg
interface bdq_req_if;
  import bdq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [VAL_W-1:0] item_value;

  modport source (output valid, req_type, item_value, input ready);
  modport sink   (input valid, req_type, item_value, output ready);
endinterface

interface bdq_rsp_if;
  import bdq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic                    found;
  logic signed [VAL_W-1:0] removed_value;
  logic [CNT_OUT_W-1:0]    entry_count;

  modport source (output valid, status, found, removed_value, entry_count, input ready);
  modport sink   (input valid, status, found, removed_value, entry_count, output ready);
endinterface

// ----- rtl/bounded_deque_with_search_unit.sv -----
// Bounded double-ended queue of signed 32-bit values with search.
// Request channel in_req carries req_type (push front/back, pop front/back,
// search, reverse) and item_value; result channel out_rsp returns one item
// per request with status, found, removed_value and entry_count.
// Requests are classified into a two-entry command queue; the back end
// executes one command at a time against a single-port ring store.
// Push, reverse, search of an empty list, empty pop and full push register
// their result directly; a pop issues the read and returns the entry from
// the S_POP state; a search reads one stored entry per cycle through the
// memory port, stops on a hit and otherwise ends with a last compare.
// Sustained rate: one item per cycle for non-memory-read commands while
// out_rsp.ready is high; a pop or search takes no new command until done.
// Reset (rst_n low, synchronous) empties the list, clears the reversal flag
// and drops queued and pending items; stored values are not cleared.
// When out_rsp.ready is low the result is held in the output register; up
// to two more requests are accepted into the queue, then in_req.ready drops.
// depends on bdq_pkg, bdq_if, bdq_front, bdq_fifo, bdq_back
module bounded_deque_with_search_unit #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  bdq_req_if.sink   in_req,
  bdq_rsp_if.source out_rsp
);
  import bdq_pkg::*;

  logic     q_push, q_full, q_vld, q_rdy;
  bdq_op_t  push_op, pop_op;
  bdq_rsp_t rsp;

  // classify incoming items
  bdq_front u_front (
    .in_vld        (in_req.valid),
    .in_req_type   (in_req.req_type),
    .in_item_value (in_req.item_value),
    .in_rdy        (in_req.ready),
    .q_push        (q_push),
    .q_op          (push_op),
    .q_full        (q_full)
  );

  // decoupling queue
  bdq_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_vld (q_push),
    .push_op  (push_op),
    .full     (q_full),
    .pop_vld  (q_vld),
    .pop_rdy  (q_rdy),
    .pop_op   (pop_op)
  );

  // execute against the ring store
  bdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_vld   (q_vld),
    .q_op    (pop_op),
    .q_rdy   (q_rdy),
    .out_vld (out_rsp.valid),
    .out_rdy (out_rsp.ready),
    .out_rsp (rsp)
  );

  assign out_rsp.status        = rsp.status;
  assign out_rsp.found         = rsp.found;
  assign out_rsp.removed_value = rsp.removed_value;
  assign out_rsp.entry_count   = rsp.entry_count;

endmodule

// ----- rtl/bdq_front.sv -----
// front end: takes request items and classifies them into queue commands
// depends on bdq_pkg
module bdq_front (
  input  logic                           in_vld,
  input  logic [bdq_pkg::REQ_W-1:0]      in_req_type,
  input  logic signed [bdq_pkg::VAL_W-1:0] in_item_value,
  output logic                           in_rdy,
  output logic                           q_push,
  output bdq_pkg::bdq_op_t               q_op,
  input  logic                           q_full
);
  import bdq_pkg::*;

  // accept whenever the command queue has room
  assign in_rdy = ~q_full;
  assign q_push = in_vld & ~q_full;

  // decode request code into operation and logical end
  always_comb begin
    q_op.kind      = OP_NOP;
    q_op.log_front = 1'b0;
    q_op.value     = in_item_value;
    case (in_req_type)
      REQ_PUSH_FRONT: begin
        q_op.kind      = OP_PUSH;
        q_op.log_front = 1'b1;
      end
      REQ_PUSH_BACK: begin
        q_op.kind      = OP_PUSH;
      end
      REQ_POP_FRONT: begin
        q_op.kind      = OP_POP;
        q_op.log_front = 1'b1;
      end
      REQ_POP_BACK: begin
        q_op.kind      = OP_POP;
      end
      REQ_SEARCH: begin
        q_op.kind      = OP_SEARCH;
      end
      REQ_REVERSE: begin
        q_op.kind      = OP_REVERSE;
      end
      default: begin
        q_op.kind      = OP_NOP;
      end
    endcase
  end

endmodule

// ----- rtl/bdq_fifo.sv -----
// small command queue between the front and back ends
// depends on bdq_pkg
module bdq_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_vld,
  input  bdq_pkg::bdq_op_t push_op,
  output logic             full,
  output logic             pop_vld,
  input  logic             pop_rdy,
  output bdq_pkg::bdq_op_t pop_op
);
  import bdq_pkg::*;

  bdq_op_t            buf_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign pop_vld = (cnt_r != '0);
  assign pop_op  = buf_r[rd_ptr_r];
  assign do_push = push_vld & ~full;
  assign do_pop  = pop_vld & pop_rdy;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ----- rtl/bdq_back.sv -----
// back end: ring store, pointers, search walk and result register
// depends on bdq_pkg
module bdq_back #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_vld,
  input  bdq_pkg::bdq_op_t q_op,
  output logic             q_rdy,
  output logic             out_vld,
  input  logic             out_rdy,
  output bdq_pkg::bdq_rsp_t out_rsp
);
  import bdq_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W+1)'(DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SEARCH
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   front_r, front_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               rev_r, rev_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [VAL_W-1:0]   key_r, key_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic               out_vld_r, out_vld_nxt;
  bdq_rsp_t           rsp_r, rsp_nxt;

  logic [VAL_W-1:0]   mem [DEPTH];
  logic [VAL_W-1:0]   rd_data_r;
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_addr;

  logic               out_free;
  logic               phys_front;
  logic [CNT_W-1:0]   off_sel;
  logic [IDX_W:0]     slot_sum;
  logic [IDX_W-1:0]   slot_off, slot_dec, front_inc;

  assign out_vld  = out_vld_r;
  assign out_rsp  = rsp_r;
  assign out_free = ~out_vld_r | out_rdy;

  // reversal swaps which physical end a logical end maps to
  assign phys_front = q_op.log_front ^ rev_r;

  // ring slot arithmetic, one compare and subtract for the wrap
  always_comb begin
    if (state_r == S_SEARCH) begin
      off_sel = idx_r;
    end else if (q_op.kind == OP_POP) begin
      off_sel = count_r - CNT_ONE;
    end else begin
      off_sel = count_r;
    end
    slot_sum  = (IDX_W+1)'(front_r) + (IDX_W+1)'(off_sel);
    slot_off  = (slot_sum >= DEPTH_X) ? IDX_W'(slot_sum - DEPTH_X) : IDX_W'(slot_sum);
    slot_dec  = (front_r == '0) ? IDX_LAST : front_r - IDX_ONE;
    front_inc = (front_r == IDX_LAST) ? '0 : front_r + IDX_ONE;
  end

  // command execution
  always_comb begin
    state_nxt   = state_r;
    front_nxt   = front_r;
    count_nxt   = count_r;
    rev_nxt     = rev_r;
    idx_nxt     = idx_r;
    key_nxt     = key_r;
    cmp_vld_nxt = cmp_vld_r;
    out_vld_nxt = out_vld_r & ~out_rdy;
    rsp_nxt     = rsp_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = slot_off;
    q_rdy       = 1'b0;

    case (state_r)
      S_IDLE: begin
        q_rdy = out_free;
        if (q_vld && out_free) begin
          rsp_nxt.status        = ST_DONE;
          rsp_nxt.found         = 1'b0;
          rsp_nxt.removed_value = '0;
          rsp_nxt.entry_count   = CNT_OUT_W'(count_r);
          out_vld_nxt           = 1'b1;
          case (q_op.kind)
            OP_PUSH: begin
              if (count_r == CNT_FULL) begin
                rsp_nxt.status = ST_FULL;
              end else begin
                mem_we = 1'b1;
                if (phys_front) begin
                  mem_addr  = slot_dec;
                  front_nxt = slot_dec;
                end
                count_nxt           = count_r + CNT_ONE;
                rsp_nxt.entry_count = CNT_OUT_W'(count_r + CNT_ONE);
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                rsp_nxt.status = ST_EMPTY;
              end else begin
                mem_re      = 1'b1;
                out_vld_nxt = 1'b0;
                if (phys_front) begin
                  mem_addr  = front_r;
                  front_nxt = front_inc;
                end
                count_nxt = count_r - CNT_ONE;
                state_nxt = S_POP;
              end
            end
            OP_SEARCH: begin
              if (count_r != '0) begin
                out_vld_nxt = 1'b0;
                key_nxt     = q_op.value;
                idx_nxt     = '0;
                cmp_vld_nxt = 1'b0;
                state_nxt   = S_SEARCH;
              end
            end
            OP_REVERSE: begin
              rev_nxt = ~rev_r;
            end
            default: begin
            end
          endcase
        end
      end
      // read data of the popped entry is back
      S_POP: begin
        out_vld_nxt           = 1'b1;
        rsp_nxt.status        = ST_DONE;
        rsp_nxt.found         = 1'b0;
        rsp_nxt.removed_value = rd_data_r;
        rsp_nxt.entry_count   = CNT_OUT_W'(count_r);
        state_nxt             = S_IDLE;
      end
      // one read issued and one compare done per cycle
      S_SEARCH: begin
        rsp_nxt.status        = ST_DONE;
        rsp_nxt.removed_value = '0;
        rsp_nxt.entry_count   = CNT_OUT_W'(count_r);
        if (cmp_vld_r && (rd_data_r == key_r)) begin
          rsp_nxt.found = 1'b1;
          out_vld_nxt   = 1'b1;
          cmp_vld_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end else if (idx_r < count_r) begin
          mem_re      = 1'b1;
          idx_nxt     = idx_r + CNT_ONE;
          cmp_vld_nxt = 1'b1;
        end else begin
          cmp_vld_nxt = 1'b0;
          if (!cmp_vld_r) begin
            rsp_nxt.found = 1'b0;
            out_vld_nxt   = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      front_r   <= '0;
      count_r   <= '0;
      rev_r     <= 1'b0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      front_r   <= front_nxt;
      count_r   <= count_nxt;
      rev_r     <= rev_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    idx_r <= idx_nxt;
    key_r <= key_nxt;
    rsp_r <= rsp_nxt;
  end

  // ring store, single port with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= q_op.value;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_addr];
    end
  end

endmodule

// ----- rtl/bdq_checker.sv -----
// port-level checks for the bounded deque with search unit, bound to the top
// depends on bdq_pkg and bounded_deque_with_search_unit_defines.svh
`include "bounded_deque_with_search_unit_defines.svh"

module bdq_checker #(
  parameter int DEPTH = 16
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [bdq_pkg::STAT_W-1:0]     out_status,
  input logic                           out_found,
  input logic signed [bdq_pkg::VAL_W-1:0] out_removed_value,
  input logic [bdq_pkg::CNT_OUT_W-1:0]  out_entry_count
);
  import bdq_pkg::*;

  // a dropped push only happens with the list at capacity
  `BDQ_CHK_NOW(a_full_at_cap, out_valid && (out_status == ST_FULL), out_entry_count == CNT_OUT_W'(DEPTH), "full status with count below capacity")

  // an empty pop reports nothing removed from an empty list
  `BDQ_CHK_NOW(a_empty_clean, out_valid && (out_status == ST_EMPTY), (out_entry_count == '0) && (out_removed_value == '0), "empty status with entries or data")

  // a hit comes only from a search, which removes nothing
  `BDQ_CHK_NOW(a_found_search, out_valid && out_found, (out_status == ST_DONE) && (out_removed_value == '0), "found flag on a non-search result")

  // stalled result holds
  `BDQ_CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_found) && $stable(out_removed_value) && $stable(out_entry_count), "stalled result changed")

  // no result right after reset
  `BDQ_CHK_RST(a_rst_quiet, !rst_n, !out_valid, "result valid after reset")

endmodule

bind bounded_deque_with_search_unit bdq_checker #(
  .DEPTH (DEPTH)
) u_bdq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_rsp.valid),
  .out_ready         (out_rsp.ready),
  .out_status        (out_rsp.status),
  .out_found         (out_rsp.found),
  .out_removed_value (out_rsp.removed_value),
  .out_entry_count   (out_rsp.entry_count)
);
